// ----- rtl/egrad_pkg.sv -----
// Types, codes and helper functions shared by the elementwise backward gradient block.
package egrad_pkg;

  localparam int unsigned VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  typedef logic [VALUE_WIDTH-1:0]   mag_t;
  typedef logic [2*VALUE_WIDTH-1:0] prod_t;

  typedef struct packed {
    logic [1:0]                    action;
    logic signed [VALUE_WIDTH-1:0] upstream_grad;
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic signed [VALUE_WIDTH-1:0] right_value;
    logic                          last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] grad_left;
    logic signed [VALUE_WIDTH-1:0] grad_right;
    logic [1:0]                    status;
    logic                          last_out;
  } out_item_t;

  typedef struct packed {
    op_e  op;
    logic sg;
    logic sx;
    logic sy;
    mag_t mg;
    mag_t mx;
    mag_t my;
    logic last;
  } mid_item_t;

  typedef struct packed {
    mag_t value;
    logic sat;
  } packed_val_t;

  function automatic mag_t mag_of(logic [VALUE_WIDTH-1:0] raw);
    return raw[VALUE_WIDTH-1] ? mag_t'(-raw) : raw;
  endfunction

  function automatic packed_val_t pack_val(logic neg, prod_t mag, logic ovf);
    mag_t        limit;
    mag_t        m;
    packed_val_t res;
    limit   = neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    res.sat = ovf || (mag > prod_t'(limit));
    m       = res.sat ? limit : mag[VALUE_WIDTH-1:0];
    res.value = neg ? mag_t'(-m) : m;
    return res;
  endfunction

endpackage

// ----- rtl/egrad_fifo.sv -----
// Small first-in first-out queue with registered storage.
module egrad_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/egrad_front.sv -----
// Front part: accepts elements, splits operands into sign and magnitude, queues them.
module egrad_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  egrad_pkg::in_item_t  in_item_i,
  output logic                 full,
  input  logic                 mid_pop_i,
  output egrad_pkg::mid_item_t mid_item_o,
  output logic                 mid_empty_o
);

  localparam int unsigned W = egrad_pkg::VALUE_WIDTH;

  egrad_pkg::mid_item_t cls;
  logic [$bits(egrad_pkg::mid_item_t)-1:0] mid_raw;

  always_comb begin
    cls.op   = egrad_pkg::op_e'(in_item_i.action);
    cls.sg   = in_item_i.upstream_grad[W-1];
    cls.sx   = in_item_i.left_value[W-1];
    cls.sy   = in_item_i.right_value[W-1];
    cls.mg   = egrad_pkg::mag_of(in_item_i.upstream_grad);
    cls.mx   = egrad_pkg::mag_of(in_item_i.left_value);
    cls.my   = egrad_pkg::mag_of(in_item_i.right_value);
    cls.last = in_item_i.last_in;
  end

  egrad_fifo #(
    .WIDTH($bits(egrad_pkg::mid_item_t)),
    .DEPTH(2)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cls),
    .full_o (full),
    .pop_i  (mid_pop_i),
    .data_o (mid_raw),
    .empty_o(mid_empty_o)
  );

  assign mid_item_o = egrad_pkg::mid_item_t'(mid_raw);

endmodule

// ----- rtl/egrad_back.sv -----
// Back part: multiplier stage, pipelined restoring dividers and saturation.
module egrad_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  egrad_pkg::mid_item_t mid_item_i,
  input  logic                 mid_empty_i,
  output logic                 mid_pop_o,
  output logic                 res_push_o,
  output egrad_pkg::out_item_t res_item_o,
  input  logic                 res_full_i
);

  localparam int unsigned W = egrad_pkg::VALUE_WIDTH;
  localparam int unsigned F = FRAC_BITS;

  typedef struct packed {
    egrad_pkg::op_e op;
    logic           neg_l;
    logic           neg_r;
    logic           dz;
    logic           last;
    egrad_pkg::mag_t val_l;
    egrad_pkg::mag_t val_r;
    logic           sat;
  } side_t;

  logic adv;

  // Multiplier stage.
  logic                 m_vld_q;
  egrad_pkg::mid_item_t m_item_q;
  egrad_pkg::prod_t     m_pgy_q, m_pgx_q, m_pyy_q;

  // Divider pipeline, one quotient bit per stage.
  logic             vld_q  [W+1];
  side_t            side_q [W+1];
  egrad_pkg::mag_t  rem1_q [W+1];
  egrad_pkg::prod_t rem2_q [W+1];
  egrad_pkg::mag_t  lo1_q  [W+1];
  egrad_pkg::mag_t  lo2_q  [W+1];
  egrad_pkg::mag_t  q1_q   [W+1];
  egrad_pkg::mag_t  q2_q   [W+1];
  egrad_pkg::mag_t  d1_q   [W+1];
  egrad_pkg::prod_t d2_q   [W+1];
  logic             ovf1_q [W+1];
  logic             ovf2_q [W+1];

  assign adv       = !(vld_q[W] && res_full_i);
  assign mid_pop_o = adv && !mid_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= !mid_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_item_q <= mid_item_i;
      m_pgy_q  <= mid_item_i.mg * mid_item_i.my;
      m_pgx_q  <= mid_item_i.mg * mid_item_i.mx;
      m_pyy_q  <= mid_item_i.my * mid_item_i.my;
    end
  end

  // Set up the dividers and resolve the operations that need no division.
  side_t                  s0;
  egrad_pkg::mag_t        rem1_init, lo1_init, lo2_init;
  egrad_pkg::prod_t       rem2_init;
  egrad_pkg::packed_val_t pl, pr;

  always_comb begin
    rem1_init = {{(W-F){1'b0}}, m_item_q.mg[W-1:W-F]};
    lo1_init  = {m_item_q.mg[W-F-1:0], {F{1'b0}}};
    rem2_init = {{(W-F){1'b0}}, m_pgx_q[2*W-1:W-F]};
    lo2_init  = {m_pgx_q[W-F-1:0], {F{1'b0}}};
    pl = egrad_pkg::pack_val(m_item_q.sg, egrad_pkg::prod_t'(m_item_q.mg), 1'b0);
    pr = pl;
    case (m_item_q.op)
      egrad_pkg::OP_ADD: begin
        pr = pl;
      end
      egrad_pkg::OP_SUB: begin
        pr = egrad_pkg::pack_val(!m_item_q.sg, egrad_pkg::prod_t'(m_item_q.mg), 1'b0);
      end
      egrad_pkg::OP_MUL: begin
        pl = egrad_pkg::pack_val(m_item_q.sg ^ m_item_q.sy, m_pgy_q >> F, 1'b0);
        pr = egrad_pkg::pack_val(m_item_q.sg ^ m_item_q.sx, m_pgx_q >> F, 1'b0);
      end
      default: begin
        pr = pl;
      end
    endcase
    s0.op    = m_item_q.op;
    s0.neg_l = m_item_q.sg ^ m_item_q.sy;
    s0.neg_r = !(m_item_q.sg ^ m_item_q.sx);
    s0.dz    = (m_item_q.my == '0);
    s0.last  = m_item_q.last;
    s0.val_l = pl.value;
    s0.val_r = pr.value;
    s0.sat   = pl.sat || pr.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s0;
      rem1_q[0] <= rem1_init;
      rem2_q[0] <= rem2_init;
      lo1_q[0]  <= lo1_init;
      lo2_q[0]  <= lo2_init;
      q1_q[0]   <= '0;
      q2_q[0]   <= '0;
      d1_q[0]   <= m_item_q.my;
      d2_q[0]   <= m_pyy_q;
      ovf1_q[0] <= (rem1_init >= m_item_q.my);
      ovf2_q[0] <= (rem2_init >= m_pyy_q);
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0]   r1, diff1;
    logic [2*W:0] r2, diff2;
    logic         ge1, ge2;

    always_comb begin
      r1    = {rem1_q[k], lo1_q[k][W-1]};
      r2    = {rem2_q[k], lo2_q[k][W-1]};
      diff1 = r1 - {1'b0, d1_q[k]};
      diff2 = r2 - {1'b0, d2_q[k]};
      ge1   = (r1 >= {1'b0, d1_q[k]});
      ge2   = (r2 >= {1'b0, d2_q[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k+1] <= side_q[k];
        rem1_q[k+1] <= ge1 ? diff1[W-1:0] : r1[W-1:0];
        rem2_q[k+1] <= ge2 ? diff2[2*W-1:0] : r2[2*W-1:0];
        lo1_q[k+1]  <= {lo1_q[k][W-2:0], 1'b0};
        lo2_q[k+1]  <= {lo2_q[k][W-2:0], 1'b0};
        q1_q[k+1]   <= {q1_q[k][W-2:0], ge1};
        q2_q[k+1]   <= {q2_q[k][W-2:0], ge2};
        d1_q[k+1]   <= d1_q[k];
        d2_q[k+1]   <= d2_q[k];
        ovf1_q[k+1] <= ovf1_q[k];
        ovf2_q[k+1] <= ovf2_q[k];
      end
    end
  end

  // Final saturation of the quotients and assembly of the result beat.
  egrad_pkg::packed_val_t fl, fr;
  side_t                  sl;

  always_comb begin
    sl = side_q[W];
    fl = egrad_pkg::pack_val(sl.neg_l, egrad_pkg::prod_t'(q1_q[W]), ovf1_q[W]);
    fr = egrad_pkg::pack_val(sl.neg_r, egrad_pkg::prod_t'(q2_q[W]), ovf2_q[W]);
    res_item_o.last_out = sl.last;
    if (sl.op == egrad_pkg::OP_DIV) begin
      if (sl.dz) begin
        res_item_o.grad_left  = '0;
        res_item_o.grad_right = '0;
        res_item_o.status     = egrad_pkg::ST_DIV_ZERO;
      end else begin
        res_item_o.grad_left  = fl.value;
        res_item_o.grad_right = fr.value;
        res_item_o.status     = (fl.sat || fr.sat) ? egrad_pkg::ST_SAT : egrad_pkg::ST_OK;
      end
    end else begin
      res_item_o.grad_left  = sl.val_l;
      res_item_o.grad_right = sl.val_r;
      res_item_o.status     = sl.sat ? egrad_pkg::ST_SAT : egrad_pkg::ST_OK;
    end
  end

  assign res_push_o = adv && vld_q[W];

endmodule

// ----- rtl/elementwise_backward_gradient_core.sv -----
// Top level of the elementwise backward gradient block.
// Both sides behave as queues. An element beat is taken on a clock edge with push high
// and full low; it carries the operation code, the upstream gradient and both forward
// operand values in signed fixed point with FRAC_BITS fraction bits.
// A result beat is shown on out_item_o whenever empty is low and is taken on an edge
// with pop high. Results leave in the order in which elements arrived, one per element.
// A new element can be taken every cycle, so the sustained rate is one element per cycle
// while the receiver keeps popping. An element passes through the multiplier register,
// the divider set-up register, the restoring divider stages that produce one quotient
// bit per stage, and the output queue.
// Every operation travels through the same pipeline, so order is preserved trivially.
// Reset empties both queues and clears every pipeline valid bit; no clearing pass is needed.
// When the receiver stops popping, the output queue fills, the pipeline holds its
// contents, then the input queue fills and full rises; no beat is lost or repeated.
module elementwise_backward_gradient_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  egrad_pkg::in_item_t  in_item_i,
  output logic                 full,
  input  logic                 pop,
  output egrad_pkg::out_item_t out_item_o,
  output logic                 empty
);

  egrad_pkg::mid_item_t mid_item;
  logic                 mid_empty, mid_pop;
  egrad_pkg::out_item_t res_item;
  logic                 res_push, res_full;
  logic [$bits(egrad_pkg::out_item_t)-1:0] out_raw;

  egrad_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .mid_pop_i  (mid_pop),
    .mid_item_o (mid_item),
    .mid_empty_o(mid_empty)
  );

  egrad_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_item_i (mid_item),
    .mid_empty_i(mid_empty),
    .mid_pop_o  (mid_pop),
    .res_push_o (res_push),
    .res_item_o (res_item),
    .res_full_i (res_full)
  );

  egrad_fifo #(
    .WIDTH($bits(egrad_pkg::out_item_t)),
    .DEPTH(4)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_item),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_raw),
    .empty_o(empty)
  );

  assign out_item_o = egrad_pkg::out_item_t'(out_raw);

endmodule
